// File: rtl/scr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_pkg: shared types, constants and lookup tables
// Holds the channel maps, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int NumConv      = 11;
  localparam int TargetRange  = 3200;
  localparam logic [3:0] BatteryCh = 4'd10;

  localparam logic [2:0] RegCalA     = 3'd0;
  localparam logic [2:0] RegCalB     = 3'd1;
  localparam logic [2:0] RegCalC     = 3'd2;
  localparam logic [2:0] RegCalD     = 3'd3;
  localparam logic [2:0] RegScale    = 3'd4;
  localparam logic [2:0] RegOrder    = 3'd5;
  localparam logic [2:0] RegMode     = 3'd6;
  localparam logic [2:0] RegInvHw    = 3'd7;

  // One classified job handed from the front to the back.
  typedef struct packed {
    logic               is_read;
    logic [3:0]         adc;
    logic [11:0]        sample;     // already inverted when needed
    logic               is_stick;
    logic               use_scale;
    logic signed [15:0] offset;
    logic [11:0]        batt;       // filter value after this beat
  } job_t;

  function automatic logic [1:0] order_map(input logic ord, input logic [1:0] idx);
    logic [1:0] r;
    r = idx;
    if (ord) begin
      case (idx)
        2'd0:    r = 2'd2;
        2'd1:    r = 2'd0;
        2'd2:    r = 2'd1;
        default: r = 2'd3;
      endcase
    end
    return r;
  endfunction

  function automatic logic [1:0] stick_fn_map(input logic [1:0] md, input logic [1:0] f);
    logic [1:0] r;
    case (md)
      2'd0:    r = (f == 2'd1) ? 2'd2 : (f == 2'd2) ? 2'd1 : f;
      2'd1:    r = f;
      2'd2:    r = 2'd3 - f;
      default: r = (f == 2'd0) ? 2'd3 : (f == 2'd3) ? 2'd0 : f;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] hw_map(input logic hw, input logic [2:0] f);
    logic [3:0] r;
    if (!hw) begin
      case (f)
        3'd6:    r = 4'd8;
        3'd7:    r = 4'd9;
        default: r = {1'b0, f};
      endcase
    end else begin
      case (f)
        3'd0:    r = 4'd3;
        3'd1:    r = 4'd2;
        3'd2:    r = 4'd1;
        3'd3:    r = 4'd0;
        3'd4:    r = 4'd5;
        3'd5:    r = 4'd8;
        3'd6:    r = 4'd6;
        default: r = 4'd4;
      endcase
    end
    return r;
  endfunction

endpackage

// File: rtl/scr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_front: sample store, battery filter and channel classification
// Accepts beats, updates state and pushes one job per beat.
// ----------------------------------------------------------------------------
module scr_front import scr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_mode,
  input  logic [3:0]  in_channel,
  input  logic [11:0] in_raw_sample,
  input  logic [15:0] in_packet_offset,
  input  logic        channel_order_r,
  input  logic [1:0]  stick_mode_r,
  input  logic        inv_hw_r,
  output job_t        job
);

  logic [11:0] store_r [NumConv];
  logic [11:0] batt_r, batt_nxt;
  logic [2:0]  idx;
  logic [1:0]  fn;
  logic [3:0]  adc;
  logic [11:0] smp;
  logic signed [12:0] diff;
  logic signed [12:0] step;

  always_comb begin
    diff = $signed({1'b0, in_raw_sample}) - $signed({1'b0, batt_r});
    step = 13'(diff / 32);   // truncate toward zero, same as 4*d/128
    batt_nxt = batt_r;
    if (!in_mode && in_channel == BatteryCh) begin
      if (batt_r == 12'd0) batt_nxt = in_raw_sample;
      else batt_nxt = batt_r + step[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumConv; i++) store_r[i] <= 12'(i);
      batt_r <= '0;
    end else if (in_valid) begin
      batt_r <= batt_nxt;
      if (!in_mode && in_channel < 4'(NumConv)) store_r[in_channel] <= in_raw_sample;
    end
  end

  always_comb begin
    idx = in_channel[2:0];
    fn  = order_map(channel_order_r, idx[1:0]);
    adc = idx[2] ? hw_map(inv_hw_r, idx)
                 : hw_map(inv_hw_r, {1'b0, stick_fn_map(stick_mode_r, fn)});
    smp = (adc < 4'(NumConv)) ? store_r[adc] : 12'd0;
    if (inv_hw_r) smp = 12'd4095 - smp;
    job.is_read   = in_mode;
    job.adc       = adc;
    job.sample    = smp;
    job.is_stick  = (adc < 4'd4);
    job.use_scale = !idx[2] && (fn == 2'd0 || fn == 2'd1);
    job.offset    = $signed(in_packet_offset);
    job.batt      = batt_nxt;
  end

endmodule

// File: rtl/scr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_queue: two-entry job queue between front and back
// Decouples acceptance from the multi-cycle calculation.
// ----------------------------------------------------------------------------
module scr_queue import scr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic empty,
  output job_t rd_data
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !rd_en) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");

endmodule

// File: rtl/scr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_back: calibration, scaling, clamp and packet conversion
// Sequencer around a radix-2 calibration divider; one job at a time.
// ----------------------------------------------------------------------------
module scr_back import scr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_take,
  input  logic [35:0] cal_r [4],
  input  logic [7:0]  scale_r,
  output logic        res_valid,
  input  logic        res_take,
  output logic [12:0] res_value,
  output logic [15:0] res_packet,
  output logic [3:0]  res_adc,
  output logic [9:0]  res_batt
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_PREP = 6'b000010, S_DIV = 6'b000100,
    S_SCL  = 6'b001000, S_FIN  = 6'b010000, S_OUT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  job_t   job_r;
  logic signed [24:0] val_r;     // working value
  logic [23:0] rem_r, quo_r, dvs_r;
  logic        neg_r, sdiv_r;
  logic [4:0]  cnt_r;
  logic [26:0] prod_r;
  logic [12:0] out_val_r;
  logic [15:0] out_pkt_r;
  logic [3:0]  out_adc_r;
  logic [9:0]  out_batt_r;
  logic        out_vld_r;

  logic [11:0] cmin, ccen, cmax;
  logic signed [13:0] cdiff, dvd;
  logic signed [24:0] num;
  logic [24:0] rem_sh;
  logic signed [24:0] clamped;
  logic [16:0] lin25;
  logic signed [17:0] lin;
  logic signed [21:0] pk15;
  logic [24:0] vabs;
  logic [18:0] vmag;
  logic [54:0] rmul;
  logic [20:0] qscl;
  logic [47:0] bmul;

  assign job_take = (state_r == S_IDLE) && job_valid;

  always_comb begin
    cmin  = cal_r[job_r.adc[1:0]][11:0];
    ccen  = cal_r[job_r.adc[1:0]][23:12];
    cmax  = cal_r[job_r.adc[1:0]][35:24];
    cdiff = $signed({2'b0, job_r.sample}) - $signed({2'b0, ccen});
    dvd   = (cdiff < 0) ? ($signed({2'b0, ccen}) - $signed({2'b0, cmin}))
                        : ($signed({2'b0, cmax}) - $signed({2'b0, ccen}));
    num   = 25'(cdiff) * 25'sd3200;
    rem_sh = {rem_r[23:0], quo_r[23]};
    // 3200*2*s/4096 = 25*s/16, then minus range
    lin25 = {1'b0, job_r.sample, 4'b0} + {2'b0, job_r.sample, 3'b0}
            + {5'b0, job_r.sample};
    lin   = $signed({1'b0, lin25[16:4]}) - 18'sd3200;
    clamped = (val_r > 25'sd3200) ? 25'sd3200 : (val_r < -25'sd3200) ? -25'sd3200 : val_r;
    pk15  = 22'(clamped) * 22'sd15;
    // Beyond 100 * range any nonzero percent clamps anyway; cap the magnitude.
    vabs  = (val_r < 0) ? 25'(-val_r) : 25'(val_r);
    vmag  = (vabs > 25'd320000) ? 19'd320000 : vabs[18:0];
    // p / 100 as p * ceil(2^34 / 100) >> 34, exact for p below 2^30
    rmul  = 55'(prod_r) * 55'd171798692;
    qscl  = rmul[54:34];
    // f * 3300 * 151 / (4095 * 51) / 10 = f * 3322 / 13923, by reciprocal
    bmul  = 48'(job_r.batt) * 48'd65585322484;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (job_valid) state_nxt = S_PREP;
      S_PREP: if (!job_r.is_read) state_nxt = S_FIN;
              else if (job_r.is_stick && dvd != 0) state_nxt = S_DIV;
              else state_nxt = S_SCL;
      S_DIV:  if (cnt_r == 5'd0) state_nxt = S_SCL;
      S_SCL:  if (sdiv_r || !job_r.use_scale) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (!out_vld_r || res_take) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && (!out_vld_r || res_take)) out_vld_r <= 1'b1;
      else if (res_take) out_vld_r <= 1'b0;
    end
  end

  // Datapath; restoring divide on magnitudes, sign applied at the end.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (job_valid) job_r <= job;
        sdiv_r <= 1'b0;
      end
      S_PREP: begin
        if (!job_r.is_stick) val_r <= 25'(lin);
        else if (dvd == 0) val_r <= (cdiff > 0) ? 25'sd3200 : (cdiff < 0) ? -25'sd3200 : '0;
        else begin
          neg_r <= (num < 0) ^ (dvd < 0);
          quo_r <= 24'(num < 0 ? -num : num);
          dvs_r <= 24'(dvd < 0 ? -dvd : dvd);
          rem_r <= '0;
          cnt_r <= 5'd23;
        end
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_r <= 24'(rem_sh - {1'b0, dvs_r}); quo_r <= {quo_r[22:0], 1'b1};
        end else begin
          rem_r <= rem_sh[23:0]; quo_r <= {quo_r[22:0], 1'b0};
        end
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) val_r <= neg_r ?
          -$signed({1'b0, quo_r[22:0], ~(rem_sh < {1'b0, dvs_r})}) :
           $signed({1'b0, quo_r[22:0], ~(rem_sh < {1'b0, dvs_r})});
      end
      S_SCL: begin
        // Capped magnitude times percent into prod_r, then divide by 100 into val_r.
        if (!sdiv_r && job_r.use_scale) begin
          neg_r  <= val_r < 0;
          prod_r <= 27'(vmag) * 27'(scale_r);
          sdiv_r <= 1'b1;
        end else if (sdiv_r) begin
          val_r <= neg_r ? -$signed({4'b0, qscl}) : $signed({4'b0, qscl});
        end
      end
      S_OUT: begin
        // Hold the waiting beat until the receiver takes it.
        if (!out_vld_r || res_take) begin
          out_adc_r  <= job_r.is_read ? job_r.adc : 4'd0;
          out_val_r  <= job_r.is_read ? 13'(clamped) : 13'd0;
          out_pkt_r  <= job_r.is_read ? 16'(22'(pk15 / 64) + 22'(job_r.offset)) : 16'd0;
          out_batt_r <= bmul[47:38];
        end
      end
      default: ;
    endcase
  end

  assign res_valid  = out_vld_r;
  assign res_value  = out_val_r;
  assign res_packet = out_pkt_r;
  assign res_adc    = out_adc_r;
  assign res_batt   = out_batt_r;

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |=> state_r == S_PREP) else $error("take without prep");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !res_take) |=> $stable(out_val_r)) else $error("result changed");

endmodule

// File: rtl/stick_channel_calibrated_rescaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stick_channel_calibrated_rescaler: calibrated stick and switch rescaler
// Stores converter samples, filters the battery channel, and turns a
// logical channel read into a clamped value and a packet word.
//
// Input channel: push a beat while full is low. Each beat is a store
// (mode 0) or a read (mode 1). The front updates the sample store and the
// battery filter in the accept cycle and queues one job per beat.
// Result channel: a beat waits on out_ while empty is low; pop takes it.
// Every input beat yields exactly one result beat, in order.
// A store passes the back's prepare, finish and output states; a read adds
// the scale state, with the percent scale a multiply and then a divide by
// 100, and a stick read first runs a 24-step restoring divide for
// calibration; the percent scale divide is a reciprocal multiply. The back
// takes one job at a time; the two-entry queue lets the front keep
// accepting while the back works. A stalled receiver holds the back in its
// output state, and the queue then fills.
// Reset (rst_n low, synchronous) restores register defaults, loads store
// entry i with i, clears the filter and empties the queue.
// Configuration writes are taken at any edge with cfg_we high; write only
// while idle.
// ----------------------------------------------------------------------------
module stick_channel_calibrated_rescaler import scr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_mode,
  input  logic [3:0]         in_channel,
  input  logic [11:0]        in_raw_sample,
  input  logic signed [15:0] in_packet_offset,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [12:0] out_rescaled_value,
  output logic [15:0]        out_packet_value,
  output logic [3:0]         out_mapped_converter_index,
  output logic [9:0]         out_battery_centivolts,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [35:0]        cfg_data
);

  logic [35:0] cal_r [4];
  logic [7:0]  scale_r;
  logic        order_r, inv_r;
  logic [1:0]  smode_r;

  job_t f_job, q_job;
  logic q_full, q_empty, q_take, acc;
  logic res_valid;

  // Hold configuration; a write lands in one register per beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) cal_r[i] <= '0;
      scale_r <= 8'd100; order_r <= 1'b0; smode_r <= 2'd1; inv_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegCalA:  cal_r[0] <= cfg_data;
        RegCalB:  cal_r[1] <= cfg_data;
        RegCalC:  cal_r[2] <= cfg_data;
        RegCalD:  cal_r[3] <= cfg_data;
        RegScale: scale_r  <= cfg_data[7:0];
        RegOrder: order_r  <= cfg_data[0];
        RegMode:  smode_r  <= cfg_data[1:0];
        RegInvHw: inv_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_full = q_full;
  assign acc     = in_push && !q_full;

  scr_front u_front (
    .clk, .rst_n, .in_valid(acc), .in_mode, .in_channel, .in_raw_sample,
    .in_packet_offset(in_packet_offset), .channel_order_r(order_r),
    .stick_mode_r(smode_r), .inv_hw_r(inv_r), .job(f_job)
  );

  scr_queue u_queue (
    .clk, .rst_n, .wr_en(acc), .wr_data(f_job), .full(q_full),
    .rd_en(q_take), .empty(q_empty), .rd_data(q_job)
  );

  scr_back u_back (
    .clk, .rst_n, .job_valid(!q_empty), .job(q_job), .job_take(q_take),
    .cal_r(cal_r), .scale_r(scale_r), .res_valid(res_valid),
    .res_take(out_pop && res_valid), .res_value(out_rescaled_value),
    .res_packet(out_packet_value), .res_adc(out_mapped_converter_index),
    .res_batt(out_battery_centivolts)
  );

  assign out_empty = !res_valid;

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty) else $error("waiting beat dropped");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !acc) else $error("accept while full");
  a_batt_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_battery_centivolts <= 10'd977) else $error("battery range");

endmodule
